@@ src/ecsc_pkg.sv @@
// ecsc_pkg: shared widths, register codes, reset values, types and helpers
// for the edge, corner and symmetry counter. No dependencies.

package ecsc_pkg;

  localparam int PIX_W      = 8;
  localparam int CNT_W      = 20;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int THR_W      = 8;
  localparam int OUT_DATA_W = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
  localparam logic [THR_W-1:0] RST_EDGE_THR     = 8'd30;
  localparam logic [THR_W-1:0] RST_CORNER_THR   = 8'd50;
  localparam logic [THR_W-1:0] RST_MIRROR_TOL   = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_EDGE_THR     = 3'd2,
    REG_CORNER_THR   = 3'd3,
    REG_MIRROR_TOL   = 3'd4
  } cfg_reg_t;

  // per-pixel position flags handed from the position counters to the datapath
  typedef struct packed {
    logic interior;
    logic pair;
    logic frame_end;
  } item_flags_t;

  typedef struct packed {
    logic [CNT_W-1:0] edge_total;
    logic [CNT_W-1:0] corner_total;
    logic [CNT_W-1:0] match_total;
    logic [CNT_W-1:0] pair_total;
  } totals_t;

  function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                               input logic inc);
    return (inc && (v != CNT_MAX)) ? (v + CNT_W'(1)) : v;
  endfunction

endpackage

@@ src/ecsc_ram.sv @@
// ecsc_ram: generic single-write, single-read RAM with registered read data.
// Old data is returned when reading the address being written. No dependencies.

module ecsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ecsc_pos.sv @@
// ecsc_pos: column and row counters, size clamping, mirror partner address
// and position flags for the pixel at the input. Uses ecsc_pkg.

module ecsc_pos #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [ecsc_pkg::CFG_W-1:0]       frame_width,
  input  logic [ecsc_pkg::CFG_W-1:0]       frame_height,
  output logic [$clog2(MAX_WIDTH)-1:0]     col,
  output logic [$clog2(MAX_WIDTH)-1:0]     mirror_addr,
  output ecsc_pkg::item_flags_t            flags
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HV = $clog2(MAX_HEIGHT + 1);

  logic [HW-1:0] row;
  logic [WW-1:0] w_eff;
  logic [HV-1:0] h_eff;
  logic [WW-1:0] col_ext;
  logic [WW-1:0] half;
  logic [WW-1:0] mir_full;
  logic          last_col;
  logic          last_row;

  // a size of zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if ({{(32-ecsc_pkg::CFG_W){1'b0}}, frame_width} > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HV'(1);
    end else if ({{(32-ecsc_pkg::CFG_W){1'b0}}, frame_height} > 32'(MAX_HEIGHT)) begin
      h_eff = HV'(MAX_HEIGHT);
    end else begin
      h_eff = HV'(frame_height);
    end
  end

  assign col_ext  = WW'(col);
  assign half     = w_eff >> 1;
  assign mir_full = w_eff - WW'(1) - col_ext;
  assign last_col = ((WW+1)'(col) + (WW+1)'(1)) >= (WW+1)'(w_eff);
  assign last_row = ((HV+1)'(row) + (HV+1)'(1)) >= (HV+1)'(h_eff);

  assign mirror_addr     = mir_full[AW-1:0];
  assign flags.interior  = (col >= AW'(2)) && (row >= HW'(2));
  assign flags.pair      = (col_ext < w_eff) && (col_ext >= (w_eff - half));
  assign flags.frame_end = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row <= '0;
        end else begin
          row <= row + HW'(1);
        end
      end else begin
        col <= col + AW'(1);
      end
    end
  end

endmodule

@@ src/ecsc_feat.sv @@
// ecsc_feat: stage after the line store read: bypass of same-cycle writes,
// 3x3 window, edge/corner/mirror tests, saturating totals and frame snapshot.
// Uses ecsc_pkg.

module ecsc_feat #(
  parameter int AW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          accept,
  input  logic [ecsc_pkg::PIX_W-1:0]    pixel,
  input  logic [AW-1:0]                 col,
  input  logic [AW-1:0]                 mirror_addr,
  input  ecsc_pkg::item_flags_t         flags,
  input  logic [ecsc_pkg::PIX_W-1:0]    q_up1,
  input  logic [ecsc_pkg::PIX_W-1:0]    q_up2,
  input  logic [ecsc_pkg::PIX_W-1:0]    q_mir,
  input  logic [ecsc_pkg::THR_W-1:0]    edge_thr,
  input  logic [ecsc_pkg::THR_W-1:0]    corner_thr,
  input  logic [ecsc_pkg::THR_W-1:0]    mirror_tol,
  output logic                          line_we,
  output logic [AW-1:0]                 line_addr,
  output logic [ecsc_pkg::PIX_W-1:0]    line1_wdata,
  output logic [ecsc_pkg::PIX_W-1:0]    line2_wdata,
  input  logic                          fin_take,
  output logic                          fin_valid,
  output ecsc_pkg::totals_t             fin_totals
);

  localparam int PW = ecsc_pkg::PIX_W;

  logic                  s1_valid;
  logic [PW-1:0]         s1_pixel;
  logic [AW-1:0]         s1_col;
  ecsc_pkg::item_flags_t s1_flags;

  logic          byp1_hit, byp2_hit, bypm_hit;
  logic [PW-1:0] byp1_data, byp2_data, bypm_data;

  // window: middle column of all three rows, and left of the centre row
  logic [PW-1:0] win_top, win_mid, win_bot, win_left;

  logic [PW-1:0] up1, up2, mir;
  logic [PW-1:0] dt, db, dl, dr, dm;
  logic          is_edge, is_corner, is_match, step;

  ecsc_pkg::totals_t totals, totals_next;

  assign up1 = byp1_hit ? byp1_data : q_up1;
  assign up2 = byp2_hit ? byp2_data : q_up2;
  assign mir = bypm_hit ? bypm_data : q_mir;

  assign step        = s1_valid && adv;
  assign line_we     = step;
  assign line_addr   = s1_col;
  assign line1_wdata = s1_pixel;
  assign line2_wdata = up1;

  assign dt = ecsc_pkg::absdiff(win_top, win_mid);
  assign db = ecsc_pkg::absdiff(win_bot, win_mid);
  assign dl = ecsc_pkg::absdiff(win_left, win_mid);
  assign dr = ecsc_pkg::absdiff(up1, win_mid);
  assign dm = ecsc_pkg::absdiff(mir, s1_pixel);

  assign is_edge   = s1_flags.interior && ((dr > edge_thr) || (db > edge_thr));
  assign is_corner = s1_flags.interior &&
                     ((dt > corner_thr) || (db > corner_thr)) &&
                     ((dl > corner_thr) || (dr > corner_thr));
  assign is_match  = s1_flags.pair && (dm < mirror_tol);

  always_comb begin
    totals_next.edge_total   = ecsc_pkg::sat_inc(totals.edge_total, is_edge);
    totals_next.corner_total = ecsc_pkg::sat_inc(totals.corner_total, is_corner);
    totals_next.match_total  = ecsc_pkg::sat_inc(totals.match_total, is_match);
    totals_next.pair_total   = ecsc_pkg::sat_inc(totals.pair_total, s1_flags.pair);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      win_top   <= '0;
      win_mid   <= '0;
      win_bot   <= '0;
      win_left  <= '0;
      totals    <= '0;
      fin_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= accept;
      end
      if (step) begin
        win_left <= win_mid;
        win_top  <= up2;
        win_mid  <= up1;
        win_bot  <= s1_pixel;
        if (s1_flags.frame_end) begin
          totals <= '0;
        end else begin
          totals <= totals_next;
        end
      end
      if (step && s1_flags.frame_end) begin
        fin_valid <= 1'b1;
      end else if (fin_take) begin
        fin_valid <= 1'b0;
      end
    end
  end

  // payload of the stage; the bypass catches the write landing on the read edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixel;
      s1_col    <= col;
      s1_flags  <= flags;
      byp1_hit  <= s1_valid && (col == s1_col);
      byp2_hit  <= s1_valid && (col == s1_col);
      bypm_hit  <= s1_valid && (mirror_addr == s1_col);
      byp1_data <= s1_pixel;
      byp2_data <= up1;
      bypm_data <= s1_pixel;
    end
    if (step && s1_flags.frame_end) begin
      fin_totals <= totals_next;
    end
  end

endmodule

@@ src/edge_corner_symmetry_counter.sv @@
// edge_corner_symmetry_counter: top level with configuration registers,
// line stores and result register. Uses ecsc_pkg, ecsc_pos, ecsc_ram, ecsc_feat.
//
//   channel  direction  word                                  handshake
//   s_*      in         pixel, one per item in raster order   tvalid/tready
//   m_*      out        frame counts and symmetry flag        tvalid/tready
//   cfg_*    in         register index and data               cfg_we, no wait
//
// one pixel per clock sustained while s_tready is high; line store reads are registered,
// so the totals are updated from the registered pixel stage, and the frame result passes
// through the snapshot register and then the output register before it shows on m_tvalid.
// reset is synchronous; the line stores are not cleared, rows are written
// before they are read.
// input stalls only while one result waits on m_* and a second is ready behind it.

module edge_corner_symmetry_counter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ecsc_pkg::PIX_W-1:0]         s_tdata,  // [7:0] pixel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ecsc_pkg::OUT_DATA_W-1:0]    m_tdata,  // [19:0] edge_count,
                                                       // [39:20] corner_count,
                                                       // [40] is_symmetric,
                                                       // [60:41] match_count
  input  logic                               cfg_we,
  input  logic [ecsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecsc_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = ecsc_pkg::CNT_W;

  logic [ecsc_pkg::CFG_W-1:0] frame_width, frame_height;
  logic [ecsc_pkg::THR_W-1:0] edge_thr, corner_thr, mirror_tol;

  logic adv, accept, fin_take, fin_valid;
  ecsc_pkg::totals_t     fin_totals;
  ecsc_pkg::item_flags_t flags;

  logic [AW-1:0]                col, mirror_addr, line_addr;
  logic                         line_we;
  logic [ecsc_pkg::PIX_W-1:0]   line1_wdata, line2_wdata, q_up1, q_up2, q_mir;

  logic [CW+3:0] lhs, rhs;
  logic          sym;

  logic [CW-1:0] out_edge, out_corner, out_match;
  logic          out_sym;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ecsc_pkg::RST_FRAME_WIDTH;
      frame_height <= ecsc_pkg::RST_FRAME_HEIGHT;
      edge_thr     <= ecsc_pkg::RST_EDGE_THR;
      corner_thr   <= ecsc_pkg::RST_CORNER_THR;
      mirror_tol   <= ecsc_pkg::RST_MIRROR_TOL;
    end else if (cfg_we) begin
      case (ecsc_pkg::cfg_reg_t'(cfg_index))
        ecsc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        ecsc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        ecsc_pkg::REG_EDGE_THR:     edge_thr     <= cfg_data[ecsc_pkg::THR_W-1:0];
        ecsc_pkg::REG_CORNER_THR:   corner_thr   <= cfg_data[ecsc_pkg::THR_W-1:0];
        ecsc_pkg::REG_MIRROR_TOL:   mirror_tol   <= cfg_data[ecsc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(fin_valid && m_tvalid && !m_tready);
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign fin_take = fin_valid && (!m_tvalid || m_tready);

  ecsc_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (col),
    .mirror_addr  (mirror_addr),
    .flags        (flags)
  );

  // line one: previous row, read at the column and at the mirror partner
  ecsc_ram #(.WIDTH(ecsc_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (line1_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (q_up1)
  );

  ecsc_ram #(.WIDTH(ecsc_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line1_mir (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (line1_wdata),
    .re    (accept),
    .raddr (mirror_addr),
    .rdata (q_mir)
  );

  // line two: the row before that
  ecsc_ram #(.WIDTH(ecsc_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line2 (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (line2_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (q_up2)
  );

  ecsc_feat #(.AW(AW)) u_feat (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .accept      (accept),
    .pixel       (s_tdata),
    .col         (col),
    .mirror_addr (mirror_addr),
    .flags       (flags),
    .q_up1       (q_up1),
    .q_up2       (q_up2),
    .q_mir       (q_mir),
    .edge_thr    (edge_thr),
    .corner_thr  (corner_thr),
    .mirror_tol  (mirror_tol),
    .line_we     (line_we),
    .line_addr   (line_addr),
    .line1_wdata (line1_wdata),
    .line2_wdata (line2_wdata),
    .fin_take    (fin_take),
    .fin_valid   (fin_valid),
    .fin_totals  (fin_totals)
  );

  // 10*matches > 7*pairs by shifts, an add and a subtract
  assign lhs = ((CW+4)'(fin_totals.match_total) << 3) +
               ((CW+4)'(fin_totals.match_total) << 1);
  assign rhs = ((CW+4)'(fin_totals.pair_total) << 3) -
               (CW+4)'(fin_totals.pair_total);
  assign sym = (fin_totals.pair_total != '0) && (lhs > rhs);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_edge   <= fin_totals.edge_total;
      out_corner <= fin_totals.corner_total;
      out_match  <= fin_totals.match_total;
      out_sym    <= sym;
    end
  end

  assign m_tdata = {3'b000, out_match, out_sym, out_corner, out_edge};

endmodule

@@ test/edge_corner_symmetry_counter_tb.sv @@
// edge_corner_symmetry_counter_tb: self-checking bench for the edge, corner and
// symmetry counter. Drives pixel frames, predicts each frame's counts and checks
// every result word. Depends on ecsc_pkg and edge_corner_symmetry_counter.
`timescale 1ns / 100ps

module edge_corner_symmetry_counter_tb;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int RANDOM_PIXELS = 600;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SCRIPT_LEN    = 32;

  typedef struct packed {
    logic [ecsc_pkg::CNT_W-1:0] edge_count;
    logic [ecsc_pkg::CNT_W-1:0] corner_count;
    logic                       is_symmetric;
    logic [ecsc_pkg::CNT_W-1:0] match_count;
  } frame_counts_t;

  // one directed step: a register write or a pixel, with counts typed in
  // where the frame's result is obvious
  typedef struct {
    bit                 is_cfg;
    ecsc_pkg::cfg_reg_t idx;
    int                 val;
    logic [7:0]         px;
    bit                 typed;
    frame_counts_t      want;
  } script_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ecsc_pkg::PIX_W-1:0]      s_tdata = '0;       // [7:0] pixel
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ecsc_pkg::OUT_DATA_W-1:0] m_tdata;  // [19:0] edge_count, [39:20] corner_count,
                                             // [40] is_symmetric, [60:41] match_count
  logic                            cfg_we = 1'b0;
  logic [ecsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ecsc_pkg::CFG_W-1:0]      cfg_data = '0;

  edge_corner_symmetry_counter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [ecsc_pkg::CFG_W-1:0] width_reg  = ecsc_pkg::RST_FRAME_WIDTH;
  logic [ecsc_pkg::CFG_W-1:0] height_reg = ecsc_pkg::RST_FRAME_HEIGHT;
  int                         edge_thr   = ecsc_pkg::RST_EDGE_THR;
  int                         corner_thr = ecsc_pkg::RST_CORNER_THR;
  int                         mirror_tol = ecsc_pkg::RST_MIRROR_TOL;
  logic [7:0]                 line_prev  [0:MAX_W-1];
  logic [7:0]                 line_prev2 [0:MAX_W-1];
  logic [7:0]                 win [0:2][0:2];
  int                         col_pos = 0;
  int                         row_pos = 0;
  logic [ecsc_pkg::CNT_W-1:0] edge_tot = '0, corner_tot = '0, match_tot = '0, pair_tot = '0;

  frame_counts_t pending_counts [$];

  int error_count     = 0;
  int pixels_sent     = 0;
  int frames_sent     = 0;
  int results_checked = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int quiet_cycles    = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{1'b1, ecsc_pkg::REG_FRAME_WIDTH,  1, 8'd0,   1'b0, '0},
    '{1'b1, ecsc_pkg::REG_FRAME_HEIGHT, 1, 8'd0,   1'b0, '0},
    // single pixel frame: nothing interior, no mirrored pair
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd255, 1'b1, '0},
    // zero sizes act as one
    '{1'b1, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b1, ecsc_pkg::REG_FRAME_HEIGHT, 0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b1, '0},
    // two wide: one pair per row, equal then fully apart
    '{1'b1, ecsc_pkg::REG_FRAME_WIDTH,  2, 8'd0,   1'b0, '0},
    '{1'b1, ecsc_pkg::REG_FRAME_HEIGHT, 1, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd10,  1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd10,  1'b1, {20'd0, 20'd0, 1'b1, 20'd1}},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd255, 1'b1, '0},
    // 3x3 with a bright centre: one edge and one corner
    '{1'b1, ecsc_pkg::REG_FRAME_WIDTH,  3, 8'd0,   1'b0, '0},
    '{1'b1, ecsc_pkg::REG_FRAME_HEIGHT, 3, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd255, 1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b1, {20'd1, 20'd1, 1'b1, 20'd3}},
    // centre exactly at the edge threshold: not an edge
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd30,  1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b0, '0},
    '{1'b0, ecsc_pkg::REG_FRAME_WIDTH,  0, 8'd0,   1'b1, {20'd0, 20'd0, 1'b1, 20'd3}}
  };

  function automatic int dim_of(input int v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int pix_gap(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic logic [ecsc_pkg::CNT_W-1:0] bump(input logic [ecsc_pkg::CNT_W-1:0] v);
    return (v == ecsc_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  // advances the frame state by one pixel; returns 1 with the counts on the
  // frame's last pixel
  function automatic bit count_pixel(input logic [7:0] px, output frame_counts_t res);
    int w, h, c, r, i, dt, db, dl, dr;
    logic [7:0] up1, up2, ctr;
    w = dim_of(int'(width_reg), MAX_W);
    h = dim_of(int'(height_reg), MAX_H);
    c = col_pos;
    r = row_pos;
    res = '0;
    up1 = line_prev[c];
    up2 = line_prev2[c];
    line_prev2[c] = up1;
    line_prev[c] = px;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = px;
    // window centre sits one row up and one column left
    if (c >= 2 && r >= 2) begin
      ctr = win[1][1];
      dt = pix_gap(win[0][1], ctr);
      db = pix_gap(win[2][1], ctr);
      dl = pix_gap(win[1][0], ctr);
      dr = pix_gap(win[1][2], ctr);
      if (dr > edge_thr || db > edge_thr) edge_tot = bump(edge_tot);
      if ((dt > corner_thr || db > corner_thr) && (dl > corner_thr || dr > corner_thr))
        corner_tot = bump(corner_tot);
    end
    if (c < w && c >= w - w / 2) begin
      pair_tot = bump(pair_tot);
      if (pix_gap(line_prev[w - 1 - c], px) < mirror_tol) match_tot = bump(match_tot);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      if (r + 1 >= h) begin
        res.edge_count   = edge_tot;
        res.corner_count = corner_tot;
        res.is_symmetric = (pair_tot != 0) &&
                           (longint'(match_tot) * 10 > longint'(pair_tot) * 7);
        res.match_count  = match_tot;
        row_pos = 0;
        edge_tot = '0;
        corner_tot = '0;
        match_tot = '0;
        pair_tot = '0;
        return 1'b1;
      end
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    return 1'b0;
  endfunction

  task automatic report(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic queue_counts(input frame_counts_t fc);
    pending_counts = {pending_counts, fc};
  endtask

  task automatic check_word(input logic [ecsc_pkg::OUT_DATA_W-1:0] word);
    frame_counts_t want;
    if (pending_counts.size() == 0) begin
      report($sformatf("result word %h with no frame outstanding", word));
      return;
    end
    want = pending_counts.pop_front();
    results_checked++;
    if (word[19:0] != want.edge_count)
      report($sformatf("edge_count %0d, predicted %0d", word[19:0], want.edge_count));
    if (word[39:20] != want.corner_count)
      report($sformatf("corner_count %0d, predicted %0d", word[39:20], want.corner_count));
    if (word[40] != want.is_symmetric)
      report($sformatf("is_symmetric %0b, predicted %0b", word[40], want.is_symmetric));
    if (word[60:41] != want.match_count)
      report($sformatf("match_count %0d, predicted %0d", word[60:41], want.match_count));
    if (word[63:61] != 3'b000)
      report($sformatf("padding bits %b not zero", word[63:61]));
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_word(m_tdata);
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("edge_corner_symmetry_counter_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [7:0] px, output bit got, output frame_counts_t res);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
    got = count_pixel(px, res);
    if (got) frames_sent++;
  endtask

  // hold the sender until every frame result is back and the pipe is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ecsc_pkg::cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[ecsc_pkg::CFG_W-1:0];
    @(posedge clk);
    case (idx)
      ecsc_pkg::REG_FRAME_WIDTH:  width_reg  = val[ecsc_pkg::CFG_W-1:0];
      ecsc_pkg::REG_FRAME_HEIGHT: height_reg = val[ecsc_pkg::CFG_W-1:0];
      ecsc_pkg::REG_EDGE_THR:     edge_thr   = val & 8'hFF;
      ecsc_pkg::REG_CORNER_THR:   corner_thr = val & 8'hFF;
      ecsc_pkg::REG_MIRROR_TOL:   mirror_tol = val & 8'hFF;
      default: ;
    endcase
  endtask

  function automatic int pick_thr();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      2, 3:    return $urandom_range(0, 255);
      default: return $urandom_range(1, 70);
    endcase
  endfunction

  function automatic int pick_dim(input int top);
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return $urandom_range(11, top);
      default: return $urandom_range(3, 10);
    endcase
  endfunction

  task automatic reconfigure(input int w, input int h);
    settle();
    write_reg(ecsc_pkg::REG_FRAME_WIDTH, w);
    write_reg(ecsc_pkg::REG_FRAME_HEIGHT, h);
    write_reg(ecsc_pkg::REG_EDGE_THR, pick_thr());
    write_reg(ecsc_pkg::REG_CORNER_THR, pick_thr());
    write_reg(ecsc_pkg::REG_MIRROR_TOL, pick_thr());
    cfg_we <= 1'b0;
  endtask

  // styles: 0 noise, 1 smooth, 2 mirrored rows, 3 flat with spikes
  task automatic run_frame(input int style);
    int w, h, x, y, v, base, spread, jit;
    bit got;
    frame_counts_t res;
    logic [7:0] row_px [0:MAX_W-1];
    w = dim_of(int'(width_reg), MAX_W);
    h = dim_of(int'(height_reg), MAX_H);
    base = $urandom_range(0, 255);
    spread = $urandom_range(0, 40);
    for (y = 0; y < h; y++) begin
      jit = $urandom_range(0, 20);
      base = base + jit - 10;
      for (x = 0; x < w; x++) begin
        jit = $urandom_range(0, 2 * spread);
        jit = jit - spread;
        case (style)
          0: v = $urandom_range(0, 255);
          1: v = base + jit;
          2: v = (x >= w - w / 2) ? int'(row_px[w - 1 - x]) + jit : $urandom_range(0, 255);
          default: begin
            if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? 255 : 0;
            else v = base;
          end
        endcase
        v = (v < 0) ? 0 : (v > 255) ? 255 : v;
        row_px[x] = v[7:0];
        send_pixel(v[7:0], got, res);
        if (got) queue_counts(res);
      end
    end
  endtask

  initial begin
    int i, start, mix;
    bit got, in_cfg;
    frame_counts_t res;
    for (i = 0; i < MAX_W; i++) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: small frames at reset thresholds
    in_cfg = 1'b0;
    for (i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].is_cfg) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        write_reg(script[i].idx, script[i].val);
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send_pixel(script[i].px, got, res);
        if (script[i].typed) queue_counts(script[i].want);
        else if (got) queue_counts(res);
      end
    end

    // one full-width row through the size clamp
    sender_idle_pct = 26;
    recv_stall_pct  = 26;
    reconfigure(2047, 1);
    run_frame($urandom_range(0, 3));

    // random frames over four idle mixes, back to back where sizes stay put
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      mix = (pixels_sent - start) * 4 / RANDOM_PIXELS;
      case (mix)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 85; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin sender_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (pixels_sent == start || $urandom_range(0, 2) == 0)
        reconfigure(pick_dim(40), pick_dim(24));
      run_frame($urandom_range(0, 3));
    end

    s_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_counts.size() != 0) report("frame results still outstanding at the end");

    $display("run covered %0d frames and %0d pixels; %0d result words checked",
             frames_sent, pixels_sent, results_checked);
    $display("sizes from 0 to 2047 incl. clamping, thresholds 0..255, four idle mixes");
    if (error_count == 0) begin
      $display("edge_corner_symmetry_counter_tb: clean");
    end else begin
      $display("edge_corner_symmetry_counter_tb: errors");
    end
    $finish;
  end

endmodule
